[hdl/tlb_fifo_lru_table_macros.svh]
// Assertion macros for the table RTL.
// Each expects clk and rst_n in scope.
`ifndef TLB_FIFO_LRU_TABLE_MACROS_SVH
`define TLB_FIFO_LRU_TABLE_MACROS_SVH

`ifndef SYNTH
`define TLBFL_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define TLBFL_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define TLBFL_ASSERT(lbl, expr, msg)
`define TLBFL_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

[hdl/tlbfl_pkg.sv]
`default_nettype none

package tlbfl_pkg;

    localparam int STAMP_W     = 32;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int INDEX_W     = 4;
    localparam int FRAME_OUT_W = 20;

    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 2'd1;

    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_FLUSH  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_WRITE = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

    // comparator result for one entry
    typedef struct packed {
        logic page_eq;
        logic stamp_lt;
    } cmp_t;

    // valid bit control toward the entry store
    typedef struct packed {
        logic clr_all;
        logic set_one;
    } vctl_t;

endpackage

`default_nettype wire

[hdl/tlbfl_cmp.sv]
`default_nettype none

module tlbfl_cmp #(
    parameter int PAGE_BITS = 20
) (
    input  wire logic [PAGE_BITS-1:0]         entry_page,
    input  wire logic [PAGE_BITS-1:0]         key_page,
    input  wire logic [tlbfl_pkg::STAMP_W-1:0] entry_stamp,
    input  wire logic [tlbfl_pkg::STAMP_W-1:0] best_stamp,
    output tlbfl_pkg::cmp_t                    res
);
    import tlbfl_pkg::*;

    always_comb
    begin
        res.page_eq  = (entry_page == key_page);
        res.stamp_lt = (entry_stamp < best_stamp);
    end

endmodule

`default_nettype wire

[hdl/tlbfl_store.sv]
`default_nettype none

module tlbfl_store #(
    parameter int ENTRIES = 16,
    parameter int WORD_W = 72,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire logic [IDX_W-1:0]  wr_idx,
    input  wire logic [WORD_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [IDX_W-1:0]  rd_idx,
    output logic [WORD_W-1:0]      rd_data,
    input  tlbfl_pkg::vctl_t       vctl,
    input  wire logic [IDX_W-1:0]  vset_idx,
    output logic [ENTRIES-1:0]     valid
);
    import tlbfl_pkg::*;

    logic [WORD_W-1:0]  mem [ENTRIES];
    logic [WORD_W-1:0]  rd_data_reg;
    logic [ENTRIES-1:0] valid_reg;

    // page, frame and stamp words; reads do not check the valid bits
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (vctl.clr_all)
        begin
            valid_reg <= '0;
        end
        else if (vctl.set_one)
        begin
            valid_reg[vset_idx] <= 1'b1;
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

`default_nettype wire

[hdl/tlb_fifo_lru_table.sv]
// Channel   Signals                          Accepted when
// in        in_valid, in_stall, mode/page/frame   in_valid && !in_stall
// out       out_valid, out_stall, hit/frame_out/entry_index/evicted
//                                              out_valid && !out_stall
// cfg       cfg_wr_en, cfg_index, cfg_data   cfg_wr_en
//
// Lookup and insert scan the n entries in use through the single read port
// of the entry store, one entry per cycle into one comparator; a lookup
// stops early on a hit and an insert on a free slot.
// Flush and the unused mode skip the scan.
// Reset leaves every entry invalid at once; no clearing pass.
// The result sits in an output register; the next item is taken once the
// result has moved there, and a full output register holds the block.
`default_nettype none

module tlb_fifo_lru_table #(
    parameter int ENTRIES = 16,
    parameter int PAGE_BITS = 20,
    parameter int FRAME_BITS = 20,
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CNT_W = $clog2(ENTRIES + 1)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        mode,
    input  wire logic [PAGE_BITS-1:0]              page,
    input  wire logic [FRAME_BITS-1:0]             frame,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   hit,
    output logic [tlbfl_pkg::FRAME_OUT_W-1:0]      frame_out,
    output logic [tlbfl_pkg::INDEX_W-1:0]          entry_index,
    output logic                                   evicted,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tlbfl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tlbfl_pkg::CFG_W-1:0]       cfg_data
);
    import tlbfl_pkg::*;

    `include "tlb_fifo_lru_table_macros.svh"

    localparam int WORD_W = PAGE_BITS + FRAME_BITS + STAMP_W;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CFG_W-1:0] v);
        logic [CFG_W+CNT_W-1:0] ve;
        logic [CFG_W+CNT_W-1:0] ee;
        ve = {{CNT_W{1'b0}}, v};
        ee = (CFG_W + CNT_W)'(ENTRIES);
        if (v == '0)
        begin
            return CNT_W'(1);
        end
        if (ve > ee)
        begin
            return CNT_W'(ENTRIES);
        end
        return ve[CNT_W-1:0];
    endfunction

    state_t                  state_reg, state_next;
    mode_t                   op_reg, op_next;
    logic [PAGE_BITS-1:0]    key_page_reg, key_page_next;
    logic [FRAME_BITS-1:0]   key_frame_reg, key_frame_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    pend_reg, pend_next;
    logic [IDX_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]        best_idx_reg, best_idx_next;
    logic [STAMP_W-1:0]      best_stamp_reg, best_stamp_next;
    logic [IDX_W-1:0]        slot_reg, slot_next;
    logic                    fill_reg, fill_next;
    logic                    res_hit_reg, res_hit_next;
    logic [FRAME_BITS-1:0]   res_frame_reg, res_frame_next;
    logic [IDX_W-1:0]        res_idx_reg, res_idx_next;
    logic                    res_evict_reg, res_evict_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    hit_reg, hit_next;
    logic [FRAME_OUT_W-1:0]  frame_out_reg, frame_out_next;
    logic [INDEX_W-1:0]      entry_index_reg, entry_index_next;
    logic                    evicted_reg, evicted_next;
    logic [STAMP_W-1:0]      stamp_reg, stamp_next;
    logic [CNT_W-1:0]        free_reg, free_next;
    logic                    policy_reg, policy_next;
    logic [CFG_W-1:0]        eiu_reg, eiu_next;

    logic [CNT_W-1:0]        n_cnt;
    logic [STAMP_W-1:0]      stamp_inc;
    logic                    st_wr_en;
    logic [IDX_W-1:0]        st_wr_idx;
    logic [WORD_W-1:0]       st_wr_data;
    logic                    st_rd_en;
    logic [IDX_W-1:0]        st_rd_idx;
    logic [WORD_W-1:0]       st_rd_data;
    vctl_t                   vctl;
    logic [IDX_W-1:0]        vset_idx;
    logic [ENTRIES-1:0]      valid;
    logic [PAGE_BITS-1:0]    rd_page;
    logic [FRAME_BITS-1:0]   rd_frame;
    logic [STAMP_W-1:0]      rd_stamp;
    cmp_t                    cmp;
    logic [IDX_W+INDEX_W-1:0]          idx_ext;
    logic [FRAME_BITS+FRAME_OUT_W-1:0] frame_ext;

    assign rd_page  = st_rd_data[WORD_W-1 -: PAGE_BITS];
    assign rd_frame = st_rd_data[STAMP_W +: FRAME_BITS];
    assign rd_stamp = st_rd_data[STAMP_W-1:0];

    assign n_cnt     = clamp_count(eiu_reg);
    assign stamp_inc = (stamp_reg == STAMP_MAX) ? stamp_reg : stamp_reg + STAMP_W'(1);
    assign idx_ext   = {{INDEX_W{1'b0}}, res_idx_reg};
    assign frame_ext = {{FRAME_OUT_W{1'b0}}, res_frame_reg};

    tlbfl_store #(
        .ENTRIES (ENTRIES),
        .WORD_W  (WORD_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (st_wr_en),
        .wr_idx   (st_wr_idx),
        .wr_data  (st_wr_data),
        .rd_en    (st_rd_en),
        .rd_idx   (st_rd_idx),
        .rd_data  (st_rd_data),
        .vctl     (vctl),
        .vset_idx (vset_idx),
        .valid    (valid)
    );

    tlbfl_cmp #(
        .PAGE_BITS (PAGE_BITS)
    ) u_cmp (
        .entry_page  (rd_page),
        .key_page    (key_page_reg),
        .entry_stamp (rd_stamp),
        .best_stamp  (best_stamp_reg),
        .res         (cmp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            stamp_reg     <= '0;
            free_reg      <= clamp_count(CFG_W'(16));
            policy_reg    <= POLICY_FIFO;
            eiu_reg       <= CFG_W'(16);
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            stamp_reg     <= stamp_next;
            free_reg      <= free_next;
            policy_reg    <= policy_next;
            eiu_reg       <= eiu_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_page_reg    <= key_page_next;
        key_frame_reg   <= key_frame_next;
        cnt_reg         <= cnt_next;
        rd_idx_reg      <= rd_idx_next;
        best_idx_reg    <= best_idx_next;
        best_stamp_reg  <= best_stamp_next;
        slot_reg        <= slot_next;
        fill_reg        <= fill_next;
        res_hit_reg     <= res_hit_next;
        res_frame_reg   <= res_frame_next;
        res_idx_reg     <= res_idx_next;
        res_evict_reg   <= res_evict_next;
        hit_reg         <= hit_next;
        frame_out_reg   <= frame_out_next;
        entry_index_reg <= entry_index_next;
        evicted_reg     <= evicted_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        key_page_next    = key_page_reg;
        key_frame_next   = key_frame_reg;
        cnt_next         = cnt_reg;
        pend_next        = pend_reg;
        rd_idx_next      = rd_idx_reg;
        best_idx_next    = best_idx_reg;
        best_stamp_next  = best_stamp_reg;
        slot_next        = slot_reg;
        fill_next        = fill_reg;
        res_hit_next     = res_hit_reg;
        res_frame_next   = res_frame_reg;
        res_idx_next     = res_idx_reg;
        res_evict_next   = res_evict_reg;
        out_valid_next   = out_valid_reg;
        hit_next         = hit_reg;
        frame_out_next   = frame_out_reg;
        entry_index_next = entry_index_reg;
        evicted_next     = evicted_reg;
        stamp_next       = stamp_reg;
        free_next        = free_reg;
        policy_next      = policy_reg;
        eiu_next         = eiu_reg;
        st_wr_en         = 1'b0;
        st_wr_idx        = rd_idx_reg;
        st_wr_data       = {rd_page, rd_frame, stamp_reg};
        st_rd_en         = 1'b0;
        st_rd_idx        = cnt_reg[IDX_W-1:0];
        vctl             = '0;
        vset_idx         = slot_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next        = mode_t'(mode);
                    key_page_next  = page;
                    key_frame_next = frame;
                    cnt_next       = '0;
                    pend_next      = 1'b0;
                    res_hit_next   = 1'b0;
                    res_frame_next = '0;
                    res_idx_next   = '0;
                    res_evict_next = 1'b0;
                    case (mode_t'(mode))
                        MODE_LOOKUP, MODE_INSERT:
                        begin
                            state_next = ST_SCAN;
                        end
                        MODE_FLUSH:
                        begin
                            vctl.clr_all = 1'b1;
                            free_next    = n_cnt;
                            state_next   = ST_DONE;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                // issue the next read while the previous entry is compared
                if (cnt_reg < n_cnt)
                begin
                    st_rd_en    = 1'b1;
                    rd_idx_next = cnt_reg[IDX_W-1:0];
                    cnt_next    = cnt_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (pend_reg)
                begin
                    if (op_reg == MODE_LOOKUP)
                    begin
                        if (valid[rd_idx_reg] && cmp.page_eq)
                        begin
                            res_hit_next   = 1'b1;
                            res_frame_next = rd_frame;
                            res_idx_next   = rd_idx_reg;
                            if (policy_reg == POLICY_LRU)
                            begin
                                st_wr_en   = 1'b1;
                                stamp_next = stamp_inc;
                            end
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        if ((free_reg != '0) && !valid[rd_idx_reg])
                        begin
                            slot_next  = rd_idx_reg;
                            fill_next  = 1'b1;
                            state_next = ST_WRITE;
                        end
                        else if ((rd_idx_reg == '0) || cmp.stamp_lt)
                        begin
                            best_idx_next   = rd_idx_reg;
                            best_stamp_next = rd_stamp;
                        end
                    end
                end
                else if (!(cnt_reg < n_cnt))
                begin
                    // all entries seen without an early stop
                    if (op_reg == MODE_LOOKUP)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        slot_next  = best_idx_reg;
                        fill_next  = 1'b0;
                        state_next = ST_WRITE;
                    end
                end
            end

            ST_WRITE:
            begin
                st_wr_en       = 1'b1;
                st_wr_idx      = slot_reg;
                st_wr_data     = {key_page_reg, key_frame_reg, stamp_reg};
                vctl.set_one   = 1'b1;
                stamp_next     = stamp_inc;
                res_idx_next   = slot_reg;
                res_evict_next = valid[slot_reg];
                if (fill_reg)
                begin
                    free_next = free_reg - CNT_W'(1);
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    hit_next         = res_hit_reg;
                    frame_out_next   = frame_ext[FRAME_OUT_W-1:0];
                    entry_index_next = idx_ext[INDEX_W-1:0];
                    evicted_next     = res_evict_reg;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_POLICY:
                begin
                    policy_next = cfg_data[0];
                end
                REG_ENTRIES:
                begin
                    eiu_next     = cfg_data;
                    vctl.clr_all = 1'b1;
                    free_next    = clamp_count(cfg_data);
                end
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign frame_out   = frame_out_reg;
    assign entry_index = entry_index_reg;
    assign evicted     = evicted_reg;

    // valid entries plus free count always make up the entries in use
    `TLBFL_ASSERT(a_free_balance, ($countones(valid) + int'(free_reg)) == int'(n_cnt), "free count out of step with valid entries")
    `TLBFL_ASSERT(a_stamp_mono, stamp_reg >= $past(stamp_reg), "stamp counter went backward")
    `TLBFL_ASSERT_IMP(a_replace_full, (state_reg == ST_WRITE) && !fill_reg, free_reg == '0, "replacement while free entries remain")
    `TLBFL_ASSERT_IMP(a_hit_lookup, (state_reg == ST_DONE) && res_hit_reg, op_reg == MODE_LOOKUP, "hit reported for a non-lookup item")
    `TLBFL_ASSERT_IMP(a_scan_range, (state_reg == ST_SCAN) && pend_reg, CNT_W'(rd_idx_reg) < n_cnt, "scan compared an entry out of use")

endmodule

`default_nettype wire

[test/tlb_fifo_lru_table_tb.sv]
module tlb_fifo_lru_table_tb;
    import tlbfl_pkg::*;

    localparam int NUM_ENTRIES = 16;
    localparam int PAGE_W      = 20;
    localparam int FRAME_W     = 20;
    localparam int IDLE_PCT    = 16;
    localparam int HANG_LIMIT  = 4000;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 150;

    localparam logic [1:0]           MODE_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;

    typedef enum logic [1:0] {
        STIM_ITEM,
        STIM_CFG,
        STIM_DRAIN
    } stim_kind_t;

    typedef struct {
        stim_kind_t           kind;
        logic [1:0]           mode;
        logic [PAGE_W-1:0]    page;
        logic [FRAME_W-1:0]   frame;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
    } stim_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
        logic [INDEX_W-1:0] entry_index;
        logic               evicted;
    } xlate_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b1;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [1:0]           mode = '0;
    logic [PAGE_W-1:0]    page = '0;
    logic [FRAME_W-1:0]   frame = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 hit;
    logic [FRAME_W-1:0]   frame_out;
    logic [INDEX_W-1:0]   entry_index;
    logic                 evicted;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    stim_t  pending[$];
    stim_t  cur;
    xlate_t expected_q[$];
    xlate_t want;
    int     items_sent = 0;
    int     results_seen = 0;
    int     faults = 0;
    int     cycle_count = 0;
    int     hang_count = 0;
    logic   calm;
    logic   cfg_fire;

    // table mirror
    logic               pol;
    logic [CFG_W-1:0]   span_reg;
    logic               ent_valid [NUM_ENTRIES];
    logic [PAGE_W-1:0]  ent_page  [NUM_ENTRIES];
    logic [FRAME_W-1:0] ent_frame [NUM_ENTRIES];
    logic [STAMP_W-1:0] ent_stamp [NUM_ENTRIES];
    logic [STAMP_W-1:0] stamp_clock;
    int unsigned        free_slots;

    tlb_fifo_lru_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .page(page),
        .frame(frame),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .frame_out(frame_out),
        .entry_index(entry_index),
        .evicted(evicted),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // no idling on either side in this window
    assign calm = (cycle_count >= 6000) && (cycle_count < 16000);

    function automatic int unsigned live_entries();
        if (span_reg == 0)
            return 1;
        if (span_reg > NUM_ENTRIES)
            return NUM_ENTRIES;
        return span_reg;
    endfunction

    function automatic logic [STAMP_W-1:0] take_stamp();
        logic [STAMP_W-1:0] s;
        s = stamp_clock;
        if (stamp_clock != STAMP_MAX)
            stamp_clock = stamp_clock + 1'b1;
        return s;
    endfunction

    task automatic clear_table();
        for (int i = 0; i < NUM_ENTRIES; i++)
            ent_valid[i] = 1'b0;
        free_slots = live_entries();
    endtask

    task automatic reset_mirror();
        pol = POLICY_FIFO;
        span_reg = 5'd16;
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            ent_page[i] = '0;
            ent_frame[i] = '0;
            ent_stamp[i] = '0;
        end
        stamp_clock = '0;
        clear_table();
    endtask

    task automatic apply_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        if (idx == REG_POLICY)
            pol = val[0];
        else if (idx == REG_ENTRIES)
        begin
            span_reg = val;
            clear_table();
        end
    endtask

    task automatic predict_translation(input logic [1:0] md, input logic [PAGE_W-1:0] pg,
                                       input logic [FRAME_W-1:0] fr);
        xlate_t      r;
        int unsigned n;
        int unsigned slot;
        logic        found;
        r = '0;
        n = live_entries();
        found = 1'b0;
        case (md)
            MODE_LOOKUP:
            begin
                for (int i = 0; i < n; i++)
                begin
                    if (!found && ent_valid[i] && ent_page[i] == pg)
                    begin
                        found = 1'b1;
                        if (pol == POLICY_LRU)
                            ent_stamp[i] = take_stamp();
                        r.hit = 1'b1;
                        r.frame_out = ent_frame[i];
                        r.entry_index = INDEX_W'(i);
                    end
                end
            end
            MODE_INSERT:
            begin
                slot = n;
                if (free_slots > 0)
                begin
                    for (int i = 0; i < n; i++)
                        if (slot == n && !ent_valid[i])
                            slot = i;
                end
                if (slot < n)
                    free_slots--;
                else
                begin
                    // oldest stamp wins, ties to lowest index
                    slot = 0;
                    for (int i = 1; i < n; i++)
                        if (ent_stamp[i] < ent_stamp[slot])
                            slot = i;
                end
                r.evicted = ent_valid[slot];
                ent_valid[slot] = 1'b1;
                ent_page[slot] = pg;
                ent_frame[slot] = fr;
                ent_stamp[slot] = take_stamp();
                r.entry_index = INDEX_W'(slot);
            end
            MODE_FLUSH:
                clear_table();
            default: ;
        endcase
        expected_q.push_back(r);
    endtask

    task automatic add_item(input logic [1:0] md, input logic [PAGE_W-1:0] pg,
                            input logic [FRAME_W-1:0] fr);
        stim_t s;
        s.kind = STIM_ITEM;
        s.mode = md;
        s.page = pg;
        s.frame = fr;
        s.reg_idx = '0;
        s.reg_val = '0;
        pending.push_back(s);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        stim_t s;
        s.kind = STIM_CFG;
        s.mode = '0;
        s.page = '0;
        s.frame = '0;
        s.reg_idx = idx;
        s.reg_val = val;
        pending.push_back(s);
    endtask

    task automatic add_drain();
        stim_t s;
        s.kind = STIM_DRAIN;
        s.mode = '0;
        s.page = '0;
        s.frame = '0;
        s.reg_idx = '0;
        s.reg_val = '0;
        pending.push_back(s);
    endtask

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // driver
    always @(posedge clk)
    begin
        cfg_fire = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predict_translation(mode, page, frame);
                items_sent <= items_sent + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending.size() == 0)
                    in_valid <= 1'b0;
                else if (pending[0].kind == STIM_ITEM)
                begin
                    if (!calm && $urandom_range(99) < IDLE_PCT)
                        in_valid <= 1'b0;
                    else
                    begin
                        cur = pending.pop_front();
                        in_valid <= 1'b1;
                        mode <= cur.mode;
                        page <= cur.page;
                        frame <= cur.frame;
                    end
                end
                else
                begin
                    // register writes and pauses wait for the block to go idle
                    in_valid <= 1'b0;
                    if (!in_valid && items_sent == results_seen)
                    begin
                        cur = pending.pop_front();
                        if (cur.kind == STIM_CFG)
                        begin
                            cfg_fire = 1'b1;
                            cfg_index <= cur.reg_idx;
                            cfg_data <= cur.reg_val;
                            apply_setting(cur.reg_idx, cur.reg_val);
                        end
                    end
                end
            end
        end
        cfg_wr_en <= cfg_fire;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $error("result item with no item outstanding");
                    faults++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, hit);
                        faults++;
                    end
                    if (frame_out !== want.frame_out)
                    begin
                        $error("frame_out: expected %0h, got %0h", want.frame_out, frame_out);
                        faults++;
                    end
                    if (entry_index !== want.entry_index)
                    begin
                        $error("entry_index: expected %0d, got %0d", want.entry_index,
                               entry_index);
                        faults++;
                    end
                    if (evicted !== want.evicted)
                    begin
                        $error("evicted: expected %0d, got %0d", want.evicted, evicted);
                        faults++;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no handshake and no register write
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
            hang_count <= 0;
        else
            hang_count <= hang_count + 1;
        if (hang_count >= HANG_LIMIT)
        begin
            $error("no progress for %0d cycles", HANG_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        logic [PAGE_W-1:0] pool [24];
        logic [PAGE_W-1:0] pg;
        logic [FRAME_W-1:0] fr;
        logic [CFG_W-1:0]  span;
        int                pool_n;
        int                roll;

        rst_n <= 1'b0;
        reset_mirror();

        // FIFO on four entries: fill, hit, evict, unused mode, flush
        add_cfg(REG_ENTRIES, 5'b00100);
        add_item(MODE_LOOKUP, 20'h00000, 20'h00000);
        add_item(MODE_INSERT, 20'h00000, 20'h00000);
        add_item(MODE_INSERT, 20'hFFFFF, 20'hFFFFF);
        add_item(MODE_INSERT, 20'h12345, 20'h2A5A5);
        add_item(MODE_INSERT, 20'hABCDE, 20'h54321);
        add_item(MODE_LOOKUP, 20'hFFFFF, 20'h00000);
        add_item(MODE_LOOKUP, 20'h00000, 20'hFFFFF);
        add_item(MODE_INSERT, 20'h77777, 20'h00001);
        add_item(MODE_UNUSED, 20'hFFFFF, 20'hFFFFF);
        add_item(MODE_FLUSH, 20'hFFFFF, 20'hFFFFF);
        add_item(MODE_LOOKUP, 20'hFFFFF, 20'h00000);
        add_item(MODE_INSERT, 20'hFFFFF, 20'h00001);
        // LRU, zero entries acts as one
        add_cfg(REG_POLICY, 5'b00001);
        add_cfg(REG_ENTRIES, 5'b00000);
        add_item(MODE_INSERT, 20'h11111, 20'h00001);
        add_item(MODE_INSERT, 20'h22222, 20'h00002);
        add_item(MODE_LOOKUP, 20'h22222, 20'h00000);
        // LRU refresh changes the victim; duplicate page insert
        add_cfg(REG_ENTRIES, 5'b00011);
        add_item(MODE_INSERT, 20'h0000A, 20'h00001);
        add_item(MODE_INSERT, 20'h0000B, 20'h00002);
        add_item(MODE_INSERT, 20'h0000C, 20'h00003);
        add_item(MODE_LOOKUP, 20'h0000A, 20'h00000);
        add_item(MODE_INSERT, 20'h0000D, 20'h00004);
        add_item(MODE_INSERT, 20'h0000D, 20'h00005);
        add_item(MODE_LOOKUP, 20'h0000D, 20'h00000);
        // write to an index beyond the registers changes nothing
        add_cfg(REG_SPARE, 5'b11010);
        add_item(MODE_LOOKUP, 20'h0000A, 20'h00000);
        // oversized entry count clamps and clears the table
        add_cfg(REG_ENTRIES, 5'b11111);
        add_cfg(REG_POLICY, 5'b11110);
        add_cfg(REG_ENTRIES, 5'b10001);
        add_item(MODE_LOOKUP, 20'h0000A, 20'h00000);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            add_cfg(REG_POLICY, {4'($urandom), 1'(ph % 2)});
            case (ph)
                0: span = 5'd16;
                1: span = 5'd1;
                2: span = 5'd31;
                3: span = 5'd0;
                4: span = 5'd17;
                default: span = 5'($urandom_range(31));
            endcase
            add_cfg(REG_ENTRIES, span);
            pool_n = $urandom_range(4, 24);
            for (int k = 0; k < 24; k++)
                pool[k] = 20'($urandom);
            pool[0] = '0;
            pool[1] = '1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2 && ph % 3 == 0)
                    add_drain();
                roll = $urandom_range(99);
                pg = pool[$urandom_range(pool_n - 1)];
                fr = 20'($urandom);
                if (roll < 45)
                    add_item(MODE_LOOKUP, pg, fr);
                else if (roll < 85)
                    add_item(MODE_INSERT, pg, fr);
                else if (roll < 90)
                    add_item(MODE_LOOKUP, 20'($urandom), fr);
                else if (roll < 93)
                    add_item(MODE_FLUSH, pg, fr);
                else if (roll < 96)
                    add_item(MODE_UNUSED, pg, fr);
                else
                    add_item(MODE_INSERT, 20'($urandom), fr);
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || in_valid || items_sent != results_seen)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (expected_q.size() != 0)
        begin
            $error("%0d result items never arrived", expected_q.size());
            faults++;
        end
        if (faults == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
